>>> design/sma_pkg.sv
// Package for the stack machine execution unit.
// Holds operation and status codes, state encoding and shared types.
// No dependencies.
package sma_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned DepthWidth = 7;

  typedef enum logic [3:0] {
    FUNC_ADD = 4'd0,
    FUNC_SUB = 4'd1,
    FUNC_MUL = 4'd2,
    FUNC_DIV = 4'd3,
    FUNC_REM = 4'd4,
    FUNC_NOT = 4'd5,
    FUNC_GT = 4'd6,
    FUNC_DUP = 4'd7,
    FUNC_SWAP = 4'd8,
    FUNC_DISC = 4'd9,
    FUNC_PUSH = 4'd10
  } func_e;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowF = 8'h66;
  localparam logic [3:0] DigitTen = 4'ha;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_B,
    ST_POP_A,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_COMPUTE,
    ST_PUSH_1,
    ST_PUSH_2,
    ST_PEEK,
    ST_PEEK_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PUSH_RES,
    PUSH_B,
    PUSH_A
  } push_sel_e;

  typedef struct packed {
    logic    pop_b;
    logic    pop_a;
    logic    div_init;
    logic    div_step;
    logic    compute;
    logic    push;
    push_sel_e push_sel;
    logic    peek;
    logic    peek_load;
    logic    start;
    logic    set_bad_digit;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic div_done;
    logic digit_ok;
  } stat_t;

endpackage

>>> design/sma_ctrl.sv
// Controller state machine of the stack machine execution unit.
// Sequences pops, divide steps, pushes and the top read. Uses sma_pkg.
module sma_ctrl import sma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] func_i,
  output logic       out_valid,
  input  logic       out_stall,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  logic [3:0] func_q, func_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      func_q <= 4'd0;
    end else begin
      state_q <= state_d;
      func_q <= func_d;
    end
  end

  always_comb begin
    state_d = state_q;
    func_d = func_q;
    ctrl_o = '0;
    ctrl_o.push_sel = PUSH_RES;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_d = func_i;
          ctrl_o.start = 1'b1;
          if (func_i == FUNC_PUSH) begin
            if (stat_i.digit_ok) begin
              state_d = ST_PUSH_1;
            end else begin
              ctrl_o.set_bad_digit = 1'b1;
              state_d = ST_PEEK;
            end
          end else if (func_i <= FUNC_DISC) begin
            state_d = ST_POP_B;
          end else begin
            state_d = ST_PEEK;
          end
        end
      end
      ST_POP_B: begin
        ctrl_o.pop_b = 1'b1;
        if (func_q == FUNC_NOT || func_q == FUNC_DUP || func_q == FUNC_DISC) begin
          state_d = (func_q == FUNC_DISC) ? ST_PEEK : ST_COMPUTE;
        end else begin
          state_d = ST_POP_A;
        end
      end
      ST_POP_A: begin
        ctrl_o.pop_a = 1'b1;
        state_d = (func_q == FUNC_DIV || func_q == FUNC_REM) ? ST_DIV_INIT : ST_COMPUTE;
      end
      ST_DIV_INIT: begin
        ctrl_o.div_init = 1'b1;
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = ST_COMPUTE;
        end
      end
      ST_COMPUTE: begin
        ctrl_o.compute = 1'b1;
        state_d = ST_PUSH_1;
      end
      ST_PUSH_1: begin
        ctrl_o.push = 1'b1;
        ctrl_o.push_sel = (func_q == FUNC_SWAP) ? PUSH_B : PUSH_RES;
        state_d = (func_q == FUNC_DUP || func_q == FUNC_SWAP) ? ST_PUSH_2 : ST_PEEK;
      end
      ST_PUSH_2: begin
        ctrl_o.push = 1'b1;
        ctrl_o.push_sel = (func_q == FUNC_SWAP) ? PUSH_A : PUSH_RES;
        state_d = ST_PEEK;
      end
      ST_PEEK: begin
        ctrl_o.peek = 1'b1;
        state_d = ST_PEEK_WAIT;
      end
      ST_PEEK_WAIT: begin
        ctrl_o.peek_load = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> design/sma_datapath.sv
// Datapath of the stack machine execution unit: stack memory, pointer,
// operand registers, radix-2 divider and result registers. Uses sma_pkg.
module sma_datapath import sma_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            func_i,
  input  logic [7:0]            char_code_i,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  output logic [1:0]            status_o,
  output logic signed [31:0]    top_value_o,
  output logic [DepthWidth-1:0] depth_o
);

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned PtrW = $clog2(StackDepth + 1);

  logic [31:0] mem [StackDepth];
  logic [PtrW-1:0] sp_q;
  logic [31:0] a_q, b_q, res_q, rd_q, top_q;
  logic [3:0] func_q;
  logic [1:0] status_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [5:0] cnt_q;
  logic neg_a_q, neg_q, zero_q;

  logic [AddrW-1:0] wr_addr, rd_addr, pop_addr, next_addr;
  logic [31:0] push_data, pop_val;
  logic empty, full;
  logic [3:0] digit;
  logic is_dec, is_hex;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] ua, ub;

  assign empty = (sp_q == '0);
  assign full = (sp_q >= PtrW'(StackDepth));
  assign is_dec = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign is_hex = (char_code_i >= CharLowA) && (char_code_i <= CharLowF);
  assign digit = is_dec ? 4'(char_code_i - CharZero) : 4'(char_code_i - CharLowA + 8'(DigitTen));

  assign stat_o.empty = empty;
  assign stat_o.full = full;
  assign stat_o.div_done = (cnt_q == 6'd32);
  assign stat_o.digit_ok = is_dec || is_hex;

  assign pop_addr = AddrW'(sp_q - 1'b1);
  assign next_addr = AddrW'(sp_q - 2'd2);
  assign wr_addr = AddrW'(sp_q);
  assign rd_addr = ctrl_i.pop_b ? next_addr : pop_addr;

  always_comb begin
    case (ctrl_i.push_sel)
      PUSH_B: push_data = b_q;
      PUSH_A: push_data = a_q;
      default: push_data = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !full) begin
      mem[wr_addr] <= push_data;
    end
    rd_q <= mem[rd_addr];
  end

  // The read port fetches the entry below the top while the first pop is
  // taken, so the second pop finds its operand already registered.
  assign pop_val = empty ? 32'd0 : rd_q;

  assign ua = a_q[31] ? 32'(-a_q) : a_q;
  assign ub = b_q[31] ? 32'(-b_q) : b_q;
  assign rem_sh = {rem_q[30:0], quo_q[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      cnt_q <= '0;
      status_q <= STATUS_OK;
    end else begin
      if (ctrl_i.start) begin
        status_q <= ctrl_i.set_bad_digit ? STATUS_BAD_DIGIT : STATUS_OK;
      end
      if ((ctrl_i.pop_a || ctrl_i.pop_b) && !empty) begin
        sp_q <= sp_q - 1'b1;
      end
      if (ctrl_i.push) begin
        if (full) begin
          status_q <= STATUS_OVERFLOW;
        end else begin
          sp_q <= sp_q + 1'b1;
        end
      end
      if (ctrl_i.div_init) begin
        cnt_q <= '0;
      end else if (ctrl_i.div_step && cnt_q != 6'd32) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      func_q <= func_i;
      a_q <= '0;
    end
    if (ctrl_i.pop_b) begin
      b_q <= pop_val;
    end
    if (ctrl_i.pop_a) begin
      a_q <= pop_val;
    end
    if (ctrl_i.div_init) begin
      quo_q <= ua;
      dvs_q <= ub;
      rem_q <= '0;
      neg_a_q <= a_q[31];
      neg_q <= a_q[31] ^ b_q[31];
      zero_q <= (b_q == '0);
    end else if (ctrl_i.div_step && cnt_q != 6'd32) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (ctrl_i.start) begin
      res_q <= {28'd0, digit};
    end else if (ctrl_i.compute) begin
      case (func_q)
        FUNC_ADD: res_q <= a_q + b_q;
        FUNC_SUB: res_q <= a_q - b_q;
        FUNC_MUL: res_q <= 32'(a_q * b_q);
        FUNC_DIV: res_q <= zero_q ? 32'd0 : (neg_q ? 32'(-quo_q) : quo_q);
        FUNC_REM: res_q <= zero_q ? 32'd0 : (neg_a_q ? 32'(-rem_q) : rem_q);
        FUNC_NOT: res_q <= {31'd0, b_q == '0};
        FUNC_GT: res_q <= {31'd0, $signed(a_q) > $signed(b_q)};
        FUNC_DUP: res_q <= b_q;
        default: res_q <= res_q;
      endcase
    end
    if (ctrl_i.peek_load) begin
      top_q <= empty ? 32'd0 : rd_q;
    end
  end

  assign status_o = status_q;
  assign top_value_o = $signed(top_q);
  assign depth_o = DepthWidth'(sp_q);

endmodule

>>> design/stack_machine_alu.sv
// Channel | signals                          | direction
// in      | in_valid, in_stall, func, char   | item in, one operation
// out     | out_valid, out_stall, status etc | item out, one result
// Divide and remainder use a radix-2 shift-subtract divider that forms
// their 32 quotient bits in turn. The stack is a memory with one write
// port and a registered read port. Reset clears the stack pointer and the
// controller; the memory itself is not cleared. A stalled result holds,
// and no new item is taken until it has gone.
module stack_machine_alu import sma_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            func_i,
  input  logic [7:0]            char_code_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status_o,
  output logic signed [31:0]    top_value_o,
  output logic [DepthWidth-1:0] depth_o
);

  ctrl_t ctrl;
  stat_t stat;

  sma_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .func_i,
    .out_valid, .out_stall, .stat_i(stat), .ctrl_o(ctrl)
  );

  sma_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni, .func_i, .char_code_i, .ctrl_i(ctrl), .stat_o(stat),
    .status_o, .top_value_o, .depth_o
  );

endmodule

>>> design/sma_checker.sv
// Port-level checker for the stack machine execution unit.
// Bound to stack_machine_alu; uses sma_pkg.
module sma_checker import sma_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            status_o,
  input logic [DepthWidth-1:0] depth_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(depth_o))
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status_o != 2'd3)
    else $error("bad status code");

endmodule

bind stack_machine_alu sma_checker u_sma_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .status_o, .depth_o
);

>>> tb/stack_machine_alu_tb.sv
// Self-checking testbench for the stack machine execution unit.
// It predicts each result from a local stack model and compares every field.
// It depends on sma_pkg and stack_machine_alu.
`timescale 1ns / 100ps

module stack_machine_alu_tb import sma_pkg::*; ();

  localparam int unsigned StackSize = StackDepthDefault;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] char_code;
  } op_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         depth;
  } stack_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] func_i = '0;
  logic [7:0] char_code_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status_o;
  logic signed [31:0] top_value_o;
  logic [DepthWidth-1:0] depth_o;

  op_item_t pending_ops[$];
  stack_result_t expected_results[$];
  logic [31:0] model_stack[StackSize];
  int unsigned model_sp = 0;
  logic model_overflow;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_from = 0;
  int unsigned hold_len = 0;
  int unsigned mismatches = 0;
  logic took = 1'b0;

  stack_machine_alu dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func_i(func_i),
    .char_code_i(char_code_i),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status_o(status_o),
    .top_value_o(top_value_o),
    .depth_o(depth_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] model_pop();
    if (model_sp == 0) return '0;
    model_sp--;
    return model_stack[model_sp];
  endfunction

  function automatic void model_push(logic [31:0] v);
    if (model_sp >= StackSize) begin
      model_overflow = 1'b1;
    end else begin
      model_stack[model_sp] = v;
      model_sp++;
    end
  endfunction

  function automatic logic [31:0] trunc_divide(logic [31:0] a, logic [31:0] b, logic want_rem);
    logic [31:0] ua;
    logic [31:0] ub;
    if (b == '0) return '0;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    if (want_rem) return a[31] ? -(ua % ub) : ua % ub;
    return (a[31] != b[31]) ? -(ua / ub) : ua / ub;
  endfunction

  function automatic stack_result_t execute_op(logic [3:0] f, logic [7:0] ch);
    stack_result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    logic [1:0] st;
    st = STATUS_OK;
    model_overflow = 1'b0;
    case (f)
      FUNC_ADD: begin b = model_pop(); a = model_pop(); model_push(a + b); end
      FUNC_SUB: begin b = model_pop(); a = model_pop(); model_push(a - b); end
      FUNC_MUL: begin b = model_pop(); a = model_pop(); model_push(a * b); end
      FUNC_DIV: begin
        b = model_pop(); a = model_pop(); model_push(trunc_divide(a, b, 1'b0));
      end
      FUNC_REM: begin
        b = model_pop(); a = model_pop(); model_push(trunc_divide(a, b, 1'b1));
      end
      FUNC_NOT: begin v = model_pop(); model_push(v == '0 ? 32'd1 : 32'd0); end
      FUNC_GT: begin
        b = model_pop(); a = model_pop();
        model_push($signed(a) > $signed(b) ? 32'd1 : 32'd0);
      end
      FUNC_DUP: begin v = model_pop(); model_push(v); model_push(v); end
      FUNC_SWAP: begin b = model_pop(); a = model_pop(); model_push(b); model_push(a); end
      FUNC_DISC: begin v = model_pop(); end
      FUNC_PUSH: begin
        if (ch >= CharZero && ch <= CharNine) begin
          model_push(32'(ch - CharZero));
        end else if (ch >= CharLowA && ch <= CharLowF) begin
          model_push(32'(ch - CharLowA) + 32'(DigitTen));
        end else begin
          st = STATUS_BAD_DIGIT;
        end
      end
      default: begin end
    endcase
    if (st == STATUS_OK && model_overflow) st = STATUS_OVERFLOW;
    res.status = st;
    res.top_value = (model_sp > 0) ? model_stack[model_sp - 1] : '0;
    res.depth = 7'(model_sp);
    return res;
  endfunction

  function automatic void add_op(logic [3:0] f, logic [7:0] ch);
    op_item_t it;
    it.func = f;
    it.char_code = ch;
    pending_ops.push_back(it);
  endfunction

  function automatic logic [7:0] random_digit_char();
    int unsigned d;
    d = $urandom_range(15);
    return (d < 10) ? CharZero + 8'(d) : CharLowA + 8'(d - 10);
  endfunction

  function automatic void add_random_ops(int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        add_op(FUNC_PUSH, random_digit_char());
      end else if (r < 85) begin
        add_op(4'($urandom_range(FUNC_DISC, FUNC_ADD)), 8'($urandom_range(255)));
      end else if (r < 90) begin
        add_op(FUNC_PUSH, 8'($urandom_range(255)));
      end else if (r < 94) begin
        add_op(4'($urandom_range(15, int'(FUNC_PUSH) + 1)), 8'($urandom_range(255)));
      end else begin
        for (int unsigned k = 0; k < 70; k++) add_op(FUNC_PUSH, random_digit_char());
        i += 69;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    took = in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      expected_results.push_back(execute_op(func_i, char_code_i));
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: status %0d top %0d depth %0d",
               status_o, top_value_o, depth_o);
        mismatches++;
      end else begin
        stack_result_t e;
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          mismatches++;
        end
        if (top_value_o !== e.top_value) begin
          $error("top_value expected %0d actual %0d", e.top_value, top_value_o);
          mismatches++;
        end
        if (depth_o !== e.depth) begin
          $error("depth expected %0d actual %0d", e.depth, depth_o);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || took)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_item_t it;
        it = pending_ops.pop_front();
        func_i <= it.func;
        char_code_i <= it.char_code;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (cycle_count >= hold_from && cycle_count < hold_from + hold_len) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || in_valid) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    add_random_ops(n);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_op(FUNC_DISC, 8'h00);
    add_op(FUNC_ADD, 8'hff);
    add_op(FUNC_PUSH, 8'h00);
    add_op(FUNC_PUSH, 8'hff);
    add_op(FUNC_PUSH, CharZero);
    add_op(FUNC_NOT, 8'h00);
    add_op(FUNC_PUSH, CharNine);
    add_op(FUNC_PUSH, CharLowA);
    add_op(FUNC_GT, 8'h00);
    add_op(FUNC_PUSH, CharLowF);
    add_op(FUNC_SWAP, 8'h00);
    // Build the most negative value: 8^8 * 8 * 8 * 2 wraps to -2^31.
    add_op(FUNC_PUSH, CharZero + 8'd8);
    add_op(FUNC_DUP, 8'h00);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_DUP, 8'h00);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_DUP, 8'h00);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_PUSH, CharZero + 8'd8);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_PUSH, CharZero + 8'd8);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_PUSH, CharZero + 8'd2);
    add_op(FUNC_MUL, 8'h00);
    add_op(FUNC_DUP, 8'h00);
    add_op(FUNC_PUSH, CharZero);
    add_op(FUNC_PUSH, CharZero + 8'd1);
    add_op(FUNC_SUB, 8'h00);
    add_op(FUNC_DIV, 8'h00);
    add_op(FUNC_SWAP, 8'h00);
    add_op(FUNC_PUSH, CharZero + 8'd7);
    add_op(FUNC_REM, 8'h00);
    add_op(FUNC_PUSH, CharZero);
    add_op(FUNC_DIV, 8'h00);
    add_op(4'd15, 8'h5a);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_ops(230);
    hold_len = LongHold;
    hold_from = cycle_count + 20;
    drain();
    run_phase(85, 0, 230);
    run_phase(0, 85, 230);
    run_phase(25, 25, 230);
    run_phase(0, 0, 230);

    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
